/* rtl/water_ripple_grid_engine_core_macros.svh */
// Assertion helpers for the ripple engine RTL.
// The module that uses them must have clk and rst_n in scope.
`ifndef WATER_RIPPLE_GRID_ENGINE_CORE_MACROS_SVH
`define WATER_RIPPLE_GRID_ENGINE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define WRGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WRGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wrge_pkg.sv */
package wrge_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;

  localparam int CELL_W     = 16;
  localparam int WAVE_RANGE = 1024;
  localparam int DAMP_SHIFT = 5;
  localparam int GRAY_MAX   = 255;
  localparam int GRAY_SHIFT = $clog2(2 * WAVE_RANGE);

  localparam int COORD_W  = 6;
  localparam int KIND_W   = 2;
  localparam int RADIUS_W = 3;
  localparam int OFS_W    = RADIUS_W + 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3);

  localparam logic [KIND_W-1:0] KIND_DISTURB  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_PROPAGATE = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_READ     = KIND_W'(2);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_gray;
    logic       op_done;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LATCH,
    DP_P_LR,
    DP_P_UD,
    DP_P_SUM,
    DP_P_WR,
    DP_D_TEST,
    DP_D_WR,
    DP_R_ISSUE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   flip;
    logic   fire;
    logic   fire_done;
    logic   fire_gray;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_grid;
    logic              clr_last;
    logic              cell_last;
    logic              ofs_last;
    logic              hit;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P_LR,
    ST_P_UD,
    ST_P_SUM,
    ST_P_WR,
    ST_D_TEST,
    ST_D_WR,
    ST_R_ISSUE,
    ST_R_FIRE
  } ctrl_state_t;

endpackage

/* rtl/wrge_ctrl.sv */
`include "water_ripple_grid_engine_core_macros.svh"

module wrge_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wrge_pkg::dp_status_t sts,
  output wrge_pkg::dp_cmd_t    cmd
);

  wrge_pkg::ctrl_state_t state_r;
  wrge_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrge_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = wrge_pkg::DP_NOP;
    busy      = 1'b1;
    case (state_r)
      wrge_pkg::ST_CLEAR: begin
        cmd.op = wrge_pkg::DP_CLEAR;
        if (sts.clr_last) begin
          state_nxt = wrge_pkg::ST_IDLE;
        end
      end
      wrge_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (sts.kind)
            wrge_pkg::KIND_DISTURB: begin
              cmd.op    = wrge_pkg::DP_LATCH;
              state_nxt = wrge_pkg::ST_D_TEST;
            end
            wrge_pkg::KIND_PROPAGATE: begin
              cmd.op    = wrge_pkg::DP_LATCH;
              cmd.flip  = 1'b1;
              state_nxt = wrge_pkg::ST_P_LR;
            end
            wrge_pkg::KIND_READ: begin
              if (sts.in_grid) begin
                cmd.op    = wrge_pkg::DP_LATCH;
                state_nxt = wrge_pkg::ST_R_ISSUE;
              end else begin
                cmd.fire = 1'b1;
              end
            end
            default: begin
              cmd.fire = 1'b1;
            end
          endcase
        end
      end
      wrge_pkg::ST_P_LR: begin
        cmd.op    = wrge_pkg::DP_P_LR;
        state_nxt = wrge_pkg::ST_P_UD;
      end
      wrge_pkg::ST_P_UD: begin
        cmd.op    = wrge_pkg::DP_P_UD;
        state_nxt = wrge_pkg::ST_P_SUM;
      end
      wrge_pkg::ST_P_SUM: begin
        cmd.op    = wrge_pkg::DP_P_SUM;
        state_nxt = wrge_pkg::ST_P_WR;
      end
      wrge_pkg::ST_P_WR: begin
        cmd.op = wrge_pkg::DP_P_WR;
        if (sts.cell_last) begin
          cmd.fire      = 1'b1;
          cmd.fire_done = 1'b1;
          state_nxt     = wrge_pkg::ST_IDLE;
        end else begin
          state_nxt = wrge_pkg::ST_P_LR;
        end
      end
      wrge_pkg::ST_D_TEST: begin
        cmd.op = wrge_pkg::DP_D_TEST;
        if (sts.hit) begin
          state_nxt = wrge_pkg::ST_D_WR;
        end else if (sts.ofs_last) begin
          cmd.fire      = 1'b1;
          cmd.fire_done = 1'b1;
          state_nxt     = wrge_pkg::ST_IDLE;
        end
      end
      wrge_pkg::ST_D_WR: begin
        cmd.op = wrge_pkg::DP_D_WR;
        if (sts.ofs_last) begin
          cmd.fire      = 1'b1;
          cmd.fire_done = 1'b1;
          state_nxt     = wrge_pkg::ST_IDLE;
        end else begin
          state_nxt = wrge_pkg::ST_D_TEST;
        end
      end
      wrge_pkg::ST_R_ISSUE: begin
        cmd.op    = wrge_pkg::DP_R_ISSUE;
        state_nxt = wrge_pkg::ST_R_FIRE;
      end
      wrge_pkg::ST_R_FIRE: begin
        cmd.fire      = 1'b1;
        cmd.fire_done = 1'b1;
        cmd.fire_gray = 1'b1;
        state_nxt     = wrge_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = wrge_pkg::ST_IDLE;
      end
    endcase
  end

  // Every result ends its operation, so the next cycle is always idle.
  `WRGE_ASSERT_NEXT(a_fire_to_idle, cmd.fire, state_r == wrge_pkg::ST_IDLE, "result issued mid-operation")
  `WRGE_ASSERT_NOW(a_prop_flips, start && !busy && sts.kind == wrge_pkg::KIND_PROPAGATE, cmd.flip, "propagate accepted without map swap")

endmodule

/* rtl/wrge_dp.sv */
`include "water_ripple_grid_engine_core_macros.svh"

module wrge_dp #(
  parameter int GRID_WIDTH  = wrge_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wrge_pkg::GRID_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wrge_pkg::in_item_t              in_item,
  input  logic                            cfg_we,
  input  logic [wrge_pkg::RADIUS_W-1:0]   cfg_wdata,
  input  wrge_pkg::dp_cmd_t               cmd,
  output wrge_pkg::dp_status_t            sts,
  output logic                            out_strobe,
  output wrge_pkg::out_item_t             out_item
);

  localparam int CELL_W   = wrge_pkg::CELL_W;
  localparam int DAMP_W   = CELL_W + 3;
  localparam int COORD_W  = wrge_pkg::COORD_W;
  localparam int POS_W    = COORD_W + 2;
  localparam int OFS_W    = wrge_pkg::OFS_W;
  localparam int RADIUS_W = wrge_pkg::RADIUS_W;
  localparam int SQ_W     = 2 * OFS_W;
  localparam int GIN_W    = wrge_pkg::GRAY_SHIFT + 1;
  localparam int GPROD_W  = GIN_W + 8;
  localparam int CELLS    = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = $clog2(GRID_WIDTH);
  localparam int ROW_W    = $clog2(GRID_HEIGHT);

  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(GRID_WIDTH);
  localparam logic [ADDR_W-1:0] FIRST_CELL = ADDR_W'(GRID_WIDTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(GRID_WIDTH - 2);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(GRID_HEIGHT - 2);

  localparam logic signed [DAMP_W-1:0] SAT_HI   = DAMP_W'(2 ** (CELL_W - 1) - 1);
  localparam logic signed [DAMP_W-1:0] SAT_LO   = DAMP_W'(-(2 ** (CELL_W - 1)));
  localparam logic signed [DAMP_W-1:0] KICK     = DAMP_W'(wrge_pkg::WAVE_RANGE);
  localparam logic signed [CELL_W-1:0] WAVE_HI  = CELL_W'(wrge_pkg::WAVE_RANGE);
  localparam logic signed [CELL_W-1:0] WAVE_LO  = CELL_W'(-wrge_pkg::WAVE_RANGE);
  localparam logic [GIN_W-1:0]         GIN_TOP  = GIN_W'(2 * wrge_pkg::WAVE_RANGE);

  function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [DAMP_W-1:0] v);
    logic signed [CELL_W-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[CELL_W-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[CELL_W-1:0];
    end else begin
      res = v[CELL_W-1:0];
    end
    return res;
  endfunction

  // Control state.
  logic                sel_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [ADDR_W-1:0]   clr_idx_r;
  logic                out_strobe_r;

  // Operation registers.
  wrge_pkg::out_item_t       out_item_r;
  logic [COORD_W-1:0]        x_r;
  logic [COORD_W-1:0]        y_r;
  logic [ADDR_W-1:0]         idx_r;
  logic [COL_W-1:0]          col_r;
  logic [ROW_W-1:0]          row_r;
  logic signed [OFS_W-1:0]   ofs_x_r;
  logic signed [OFS_W-1:0]   ofs_y_r;
  logic signed [CELL_W:0]    sum_lr_r;
  logic signed [CELL_W-1:0]  old_r;
  logic signed [DAMP_W-1:0]  h_r;

  // Height maps and their registered read ports.
  logic signed [CELL_W-1:0] map_a_mem [CELLS];
  logic signed [CELL_W-1:0] map_b_mem [CELLS];
  logic signed [CELL_W-1:0] a_q0_r;
  logic signed [CELL_W-1:0] a_q1_r;
  logic signed [CELL_W-1:0] b_q0_r;
  logic signed [CELL_W-1:0] b_q1_r;

  logic [ADDR_W-1:0]        p0_addr;
  logic [ADDR_W-1:0]        p1_addr;
  logic [ADDR_W-1:0]        q0_addr;
  logic [ADDR_W-1:0]        a_ra0;
  logic [ADDR_W-1:0]        b_ra0;
  logic [ADDR_W-1:0]        w_addr;
  logic signed [CELL_W-1:0] w_data;
  logic                     a_we;
  logic                     b_we;
  logic                     sec_we;
  logic                     clr_we;
  logic signed [CELL_W-1:0] pd0;
  logic signed [CELL_W-1:0] pd1;
  logic signed [CELL_W-1:0] sd0;

  logic signed [OFS_W-1:0]  rad_s;
  logic signed [OFS_W-1:0]  neg_r;
  logic signed [SQ_W-1:0]   sq_x;
  logic signed [SQ_W-1:0]   sq_y;
  logic [SQ_W-1:0]          dist_sq;
  logic [2*RADIUS_W-1:0]    r_sq;
  logic signed [POS_W-1:0]  xo;
  logic signed [POS_W-1:0]  yo;
  logic                     in_circle;
  logic                     inner_x;
  logic                     inner_y;
  logic                     hit;
  logic                     ofs_last;
  logic [ADDR_W-1:0]        dist_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [OFS_W-1:0]  ofs_x_nxt;
  logic signed [OFS_W-1:0]  ofs_y_nxt;

  logic [ADDR_W-1:0]        idx_nxt;
  logic [COL_W-1:0]         col_nxt;
  logic [ROW_W-1:0]         row_nxt;
  logic                     cell_last;
  logic signed [CELL_W:0]   sum_lr_nxt;
  logic signed [CELL_W+1:0] sum4;
  logic signed [CELL_W+1:0] half;
  logic signed [DAMP_W-1:0] h_nxt;
  logic signed [DAMP_W-1:0] damped;
  logic signed [CELL_W-1:0] prop_val;
  logic signed [CELL_W-1:0] dist_val;

  logic signed [CELL_W-1:0] biased;
  logic [GIN_W-1:0]         gin;
  logic [GPROD_W-1:0]       gprod;
  logic [7:0]               gray;

  // Brush geometry for the current offset.
  assign rad_s     = $signed({1'b0, radius_r});
  assign neg_r     = -rad_s;
  assign sq_x      = SQ_W'(ofs_x_r) * SQ_W'(ofs_x_r);
  assign sq_y      = SQ_W'(ofs_y_r) * SQ_W'(ofs_y_r);
  assign dist_sq   = sq_x + sq_y;
  assign r_sq      = (2 * RADIUS_W)'(radius_r) * (2 * RADIUS_W)'(radius_r);
  assign in_circle = dist_sq < SQ_W'(r_sq);
  assign xo        = $signed({2'b00, x_r}) + POS_W'(ofs_x_r);
  assign yo        = $signed({2'b00, y_r}) + POS_W'(ofs_y_r);
  assign inner_x   = (xo > 0) && (int'(xo) < GRID_WIDTH - 1);
  assign inner_y   = (yo > 0) && (int'(yo) < GRID_HEIGHT - 1);
  assign hit       = in_circle && inner_x && inner_y;
  assign ofs_last  = (ofs_x_r == rad_s) && (ofs_y_r == rad_s);
  assign dist_addr = ADDR_W'(int'(yo) * GRID_WIDTH + int'(xo));
  assign rd_addr   = ADDR_W'(int'(y_r) * GRID_WIDTH + int'(x_r));

  always_comb begin
    if (ofs_x_r == rad_s) begin
      ofs_x_nxt = neg_r;
      ofs_y_nxt = ofs_y_r + OFS_W'(1);
    end else begin
      ofs_x_nxt = ofs_x_r + OFS_W'(1);
      ofs_y_nxt = ofs_y_r;
    end
  end

  // Raster walk over the interior; the row wrap skips both border columns.
  assign cell_last = (col_r == LAST_COL) && (row_r == LAST_ROW);

  always_comb begin
    if (col_r == LAST_COL) begin
      col_nxt = COL_W'(1);
      row_nxt = row_r + ROW_W'(1);
      idx_nxt = idx_r + ADDR_W'(3);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  // The primary map is the newer one for propagate and the displayed one for
  // reads; the secondary map is the one that disturb and propagate write.
  always_comb begin
    p0_addr = idx_r - ADDR_W'(1);
    p1_addr = idx_r + ADDR_W'(1);
    q0_addr = idx_r;
    case (cmd.op)
      wrge_pkg::DP_P_UD: begin
        p0_addr = idx_r - ROW_STEP;
        p1_addr = idx_r + ROW_STEP;
      end
      wrge_pkg::DP_R_ISSUE: begin
        p0_addr = rd_addr;
      end
      wrge_pkg::DP_D_TEST, wrge_pkg::DP_D_WR: begin
        q0_addr = dist_addr;
      end
      default: begin
      end
    endcase
  end

  assign a_ra0  = sel_r ? p0_addr : q0_addr;
  assign b_ra0  = sel_r ? q0_addr : p0_addr;
  assign pd0    = sel_r ? a_q0_r : b_q0_r;
  assign pd1    = sel_r ? a_q1_r : b_q1_r;
  assign sd0    = sel_r ? b_q0_r : a_q0_r;

  assign clr_we = (cmd.op == wrge_pkg::DP_CLEAR);
  assign sec_we = (cmd.op == wrge_pkg::DP_P_WR) || (cmd.op == wrge_pkg::DP_D_WR);
  assign a_we   = clr_we || (sec_we && !sel_r);
  assign b_we   = clr_we || (sec_we && sel_r);
  assign w_addr = clr_we ? clr_idx_r : q0_addr;

  always_comb begin
    if (clr_we) begin
      w_data = '0;
    end else if (cmd.op == wrge_pkg::DP_P_WR) begin
      w_data = prop_val;
    end else begin
      w_data = dist_val;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      map_a_mem[w_addr] <= w_data;
    end
    a_q0_r <= map_a_mem[a_ra0];
    a_q1_r <= map_a_mem[p1_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      map_b_mem[w_addr] <= w_data;
    end
    b_q0_r <= map_b_mem[b_ra0];
    b_q1_r <= map_b_mem[p1_addr];
  end

  // Wave update arithmetic.
  assign sum_lr_nxt = (CELL_W + 1)'(pd0) + (CELL_W + 1)'(pd1);
  assign sum4       = (CELL_W + 2)'(sum_lr_r) + (CELL_W + 2)'(pd0) + (CELL_W + 2)'(pd1);
  assign half       = sum4 >>> 1;
  assign h_nxt      = DAMP_W'(half) - DAMP_W'(old_r);
  assign damped     = h_r - (h_r >>> wrge_pkg::DAMP_SHIFT);
  assign prop_val   = sat_cell(damped);
  assign dist_val   = sat_cell(DAMP_W'(sd0) - KICK);

  // Gray level: clamp to the wave range, then scale 0..2048 onto 0..255.
  assign biased = pd0 + WAVE_HI;

  always_comb begin
    if (pd0 < WAVE_LO) begin
      gin = '0;
    end else if (pd0 > WAVE_HI) begin
      gin = GIN_TOP;
    end else begin
      gin = biased[GIN_W-1:0];
    end
  end

  assign gprod = GPROD_W'(gin) * GPROD_W'(wrge_pkg::GRAY_MAX);
  assign gray  = gprod[wrge_pkg::GRAY_SHIFT +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r        <= 1'b0;
      radius_r     <= wrge_pkg::RADIUS_RESET;
      clr_idx_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      if (cmd.flip) begin
        sel_r <= ~sel_r;
      end
      if (clr_we) begin
        clr_idx_r <= clr_idx_r + ADDR_W'(1);
      end
      out_strobe_r <= cmd.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_item_r.op_done    <= cmd.fire_done;
      out_item_r.pixel_gray <= cmd.fire_gray ? gray : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      wrge_pkg::DP_LATCH: begin
        x_r     <= in_item.x_coord;
        y_r     <= in_item.y_coord;
        idx_r   <= FIRST_CELL;
        col_r   <= COL_W'(1);
        row_r   <= ROW_W'(1);
        ofs_x_r <= neg_r;
        ofs_y_r <= neg_r;
      end
      wrge_pkg::DP_P_UD: begin
        sum_lr_r <= sum_lr_nxt;
        old_r    <= sd0;
      end
      wrge_pkg::DP_P_SUM: begin
        h_r <= h_nxt;
      end
      wrge_pkg::DP_P_WR: begin
        idx_r <= idx_nxt;
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      wrge_pkg::DP_D_TEST: begin
        if (!hit) begin
          ofs_x_r <= ofs_x_nxt;
          ofs_y_r <= ofs_y_nxt;
        end
      end
      wrge_pkg::DP_D_WR: begin
        ofs_x_r <= ofs_x_nxt;
        ofs_y_r <= ofs_y_nxt;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts           = '0;
    sts.kind      = in_item.kind;
    sts.in_grid   = (int'(in_item.x_coord) < GRID_WIDTH) && (int'(in_item.y_coord) < GRID_HEIGHT);
    sts.clr_last  = (clr_idx_r == LAST_ADDR);
    sts.cell_last = cell_last;
    sts.ofs_last  = ofs_last;
    sts.hit       = hit;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Border cells are never rewritten by the wave update.
  `WRGE_ASSERT_NOW(a_prop_interior, cmd.op == wrge_pkg::DP_P_WR, col_r != '0 && row_r != '0, "wave update on a border cell")
  `WRGE_ASSERT_NOW(a_undone_gray, out_strobe_r && !out_item_r.op_done, out_item_r.pixel_gray == 8'd0, "gray level on an undone beat")
  `WRGE_ASSERT_NEXT(a_sel_hold, !cmd.flip, $stable(sel_r), "map select changed without a swap")

endmodule

/* rtl/water_ripple_grid_engine_core.sv */
// Channel   Handshake            Payload                        Beat taken
// input     start / busy         in_item (kind, x_coord, y_coord) start high, busy low
// result    out_strobe           out_item (pixel_gray, op_done)  every strobe cycle
// config    cfg_we               cfg_wdata (brush_radius)        every cfg_we cycle
//
// After reset a clearing pass zeroes every cell of both maps, busy high.
// Propagate walks every interior cell through P_LR, P_UD, P_SUM and P_WR, a read-compute-write
// walk over the two-read-port height maps, once the operation is accepted. Disturb tests each
// offset of the (2r+1)-wide square and lowers each cell it hits; a read passes through R_ISSUE
// and R_FIRE; an unused kind or off-grid read fires on accept. Config writes are taken in any
// cycle. The result strobe is registered after the last step; it cannot be held off.
module water_ripple_grid_engine_core #(
  parameter int GRID_WIDTH  = wrge_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wrge_pkg::GRID_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  wrge_pkg::in_item_t            in_item,
  input  logic                          cfg_we,
  input  logic [wrge_pkg::RADIUS_W-1:0] cfg_wdata,
  output logic                          out_strobe,
  output wrge_pkg::out_item_t           out_item
);

  wrge_pkg::dp_cmd_t    cmd;
  wrge_pkg::dp_status_t sts;

  wrge_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  wrge_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
